[design/pattern_overlay_alpha_blend_macros.svh]
// Assertion macros shared by the pattern overlay RTL.
`ifndef PATTERN_OVERLAY_ALPHA_BLEND_MACROS_SVH
`define PATTERN_OVERLAY_ALPHA_BLEND_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define POB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define POB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define POB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pob_pkg.sv]
// Types, constants and helpers for the pattern overlay alpha blender.
package pob_pkg;

  localparam int COORD_W     = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QLW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_BLEND = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_PATTERN_WIDTH  = 3'd2,
    REG_PATTERN_HEIGHT = 3'd3,
    REG_COLOR_RED      = 3'd4,
    REG_COLOR_GREEN    = 3'd5,
    REG_COLOR_BLUE     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic               action;
    logic [11:0]        mask_addr;
    logic [7:0]         mask_value;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       covered;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [6:0]         pattern_width;
    logic [6:0]         pattern_height;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;
  } cfg_t;

  // One classified pixel waiting for the blend datapath.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       covered;
  } q_entry_t;

  typedef struct packed {
    logic [QLW-1:0] level;
    logic           empty;
    logic           full;
  } q_stat_t;

  // floor(s / 255), exact for s below 65280.
  function automatic logic [7:0] div255(input logic [15:0] s);
    logic [16:0] t;
    t = 17'(s) + 17'(s[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

[design/pob_ram.sv]
// Generic single-port RAM with registered read data.
module pob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pob_front.sv]
// Front end: accepts items, clears and loads the mask, classifies pixels.
module pob_front #(
  parameter int MAX_SIDE   = 64,
  parameter int COORD_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pob_pkg::in_item_t in_item_i,
  input  pob_pkg::cfg_t     cfg_i,
  input  pob_pkg::q_stat_t  q_stat_i,
  output logic              q_push_o,
  output pob_pkg::q_entry_t q_entry_o
);
  import pob_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int OW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int DW    = CW + 2;

  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          s1_v_q;
  logic [7:0]    s1_r_q, s1_g_q, s1_b_q;
  logic          s1_cov_q;

  logic                 room, accept, is_blend, addr_ok;
  logic [SW-1:0]        w, h;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        dx_u, dy_u;
  logic                 in_x, in_y, covered;
  logic [AW-1:0]        mask_idx;
  logic                 ram_en, ram_we;
  logic [AW-1:0]        ram_addr;
  logic [7:0]           ram_wdata, ram_rdata;

  assign room = ((QLW+1)'(q_stat_i.level) + (QLW+1)'(s1_v_q)) < (QLW+1)'(QUEUE_DEPTH);
  assign in_stall_o = clr_busy_q || !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_blend   = (in_item_i.action == ACT_BLEND);
  assign addr_ok    = 32'(in_item_i.mask_addr) < DEPTH;

  always_comb begin
    if (32'(cfg_i.pattern_width) > MAX_SIDE) begin
      w = SW'(MAX_SIDE);
    end else begin
      w = SW'(cfg_i.pattern_width);
    end
    if (32'(cfg_i.pattern_height) > MAX_SIDE) begin
      h = SW'(MAX_SIDE);
    end else begin
      h = SW'(cfg_i.pattern_height);
    end
  end

  // Offset from the box's upper-left corner.
  assign dx = $signed({2'b00, in_item_i.pixel_x[CW-1:0]})
            - $signed({2'b00, cfg_i.center_x[CW-1:0]})
            + $signed(DW'(w >> 1));
  assign dy = $signed({2'b00, in_item_i.pixel_y[CW-1:0]})
            - $signed({2'b00, cfg_i.center_y[CW-1:0]})
            + $signed(DW'(h >> 1));
  assign dx_u = dx;
  assign dy_u = dy;

  assign in_x    = !dx[DW-1] && (dx_u < DW'(w));
  assign in_y    = !dy[DW-1] && (dy_u < DW'(h));
  assign covered = in_x && in_y;
  assign mask_idx = AW'(dy_u[OW-1:0] * MAX_SIDE + 32'(dx_u[OW-1:0]));

  always_comb begin
    if (clr_busy_q) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = 8'd0;
    end else begin
      ram_en    = accept;
      ram_we    = !is_blend && addr_ok;
      ram_addr  = is_blend ? mask_idx : AW'(in_item_i.mask_addr);
      ram_wdata = in_item_i.mask_value;
    end
  end

  pob_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_mask_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_v_q     <= 1'b0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
      s1_v_q     <= accept && is_blend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_r_q   <= in_item_i.in_red;
      s1_g_q   <= in_item_i.in_green;
      s1_b_q   <= in_item_i.in_blue;
      s1_cov_q <= covered;
    end
  end

  // Uncovered pixels blend with zero opacity, which passes them through.
  assign q_push_o          = s1_v_q;
  assign q_entry_o.red     = s1_r_q;
  assign q_entry_o.green   = s1_g_q;
  assign q_entry_o.blue    = s1_b_q;
  assign q_entry_o.alpha   = s1_cov_q ? ram_rdata : 8'd0;
  assign q_entry_o.covered = s1_cov_q;

endmodule

[design/pob_fifo.sv]
// Short queue between the front end and the blend datapath.
module pob_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pob_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output pob_pkg::q_entry_t head_o,
  output pob_pkg::q_stat_t  stat_o
);
  import pob_pkg::*;

  q_entry_t       buf_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLW-1:0] level_q, level_d;

  always_comb begin
    level_d = level_q;
    if (push_i && !pop_i) begin
      level_d = level_q + QLW'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - QLW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      level_q <= level_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o       = buf_q[rd_ptr_q];
  assign stat_o.level = level_q;
  assign stat_o.empty = (level_q == '0);
  assign stat_o.full  = (level_q == QLW'(QUEUE_DEPTH));

endmodule

[design/pob_back.sv]
// Blend datapath: products and sums, then divide by 255 into the output register.
module pob_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pob_pkg::cfg_t      cfg_i,
  input  pob_pkg::q_entry_t  head_i,
  input  pob_pkg::q_stat_t   q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pob_pkg::out_item_t out_item_o
);
  import pob_pkg::*;

  logic        b1_v_q, out_v_q;
  logic [15:0] b1_sum_q [3];
  logic        b1_cov_q;
  out_item_t   out_q;

  logic        en_out, en_b1;
  logic [7:0]  inv_a;
  logic [15:0] sum_d [3];

  assign en_out = !out_v_q || !out_stall_i;
  assign en_b1  = en_out || !b1_v_q;
  assign pop_o  = en_b1 && !q_stat_i.empty;

  assign inv_a = 8'd255 - head_i.alpha;
  assign sum_d[0] = 16'(cfg_i.color_red) * 16'(head_i.alpha)
                  + 16'(head_i.red) * 16'(inv_a);
  assign sum_d[1] = 16'(cfg_i.color_green) * 16'(head_i.alpha)
                  + 16'(head_i.green) * 16'(inv_a);
  assign sum_d[2] = 16'(cfg_i.color_blue) * 16'(head_i.alpha)
                  + 16'(head_i.blue) * 16'(inv_a);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_b1) begin
        b1_v_q <= pop_o;
      end
      if (en_out) begin
        out_v_q <= b1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_sum_q[0] <= sum_d[0];
      b1_sum_q[1] <= sum_d[1];
      b1_sum_q[2] <= sum_d[2];
      b1_cov_q    <= head_i.covered;
    end
    if (en_out && b1_v_q) begin
      out_q.out_red   <= div255(b1_sum_q[0]);
      out_q.out_green <= div255(b1_sum_q[1]);
      out_q.out_blue  <= div255(b1_sum_q[2]);
      out_q.covered   <= b1_cov_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

[design/pattern_overlay_alpha_blend.sv]
// Pattern overlay alpha blender top level: config registers, front end, queue, blend datapath.
//
// Takes one item per clock while in_stall_o is low. A load item writes one
// opacity byte, if its mask address is in range, and gives no result. A pixel
// item's result passes through the mask RAM read, then the queue write, the
// product/sum stage and the divide-by-255 output register.
// The rate is set by the single mask RAM port, shared by loads and reads, and
// the four-entry queue absorbs short output stalls before the input stalls.
// After reset the mask RAM is zeroed one entry per cycle, all MAX_SIDE*MAX_SIDE
// entries (4096 at the default), while the input is stalled. Configuration
// writes are accepted at any time. Pixels still in flight see the new values,
// so write registers only while no transaction is in flight.
module pattern_overlay_alpha_blend #(
  parameter int MAX_SIDE   = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pob_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pob_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pob_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pob_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pob_pkg::*;
  `include "pattern_overlay_alpha_blend_macros.svh"

  cfg_t     cfg_q, cfg_d;
  q_stat_t  q_stat;
  q_entry_t q_entry, q_head;
  logic     q_push, q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CENTER_X:       cfg_d.center_x       = cfg_data_i[COORD_W-1:0];
        REG_CENTER_Y:       cfg_d.center_y       = cfg_data_i[COORD_W-1:0];
        REG_PATTERN_WIDTH:  cfg_d.pattern_width  = cfg_data_i[6:0];
        REG_PATTERN_HEIGHT: cfg_d.pattern_height = cfg_data_i[6:0];
        REG_COLOR_RED:      cfg_d.color_red      = cfg_data_i[7:0];
        REG_COLOR_GREEN:    cfg_d.color_green    = cfg_data_i[7:0];
        REG_COLOR_BLUE:     cfg_d.color_blue     = cfg_data_i[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x       <= '0;
      cfg_q.center_y       <= '0;
      cfg_q.pattern_width  <= 7'd1;
      cfg_q.pattern_height <= 7'd1;
      cfg_q.color_red      <= '0;
      cfg_q.color_green    <= '0;
      cfg_q.color_blue     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pob_front #(
    .MAX_SIDE  (MAX_SIDE),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  pob_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  pob_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (q_head),
    .q_stat_i   (q_stat),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  `POB_ASSERT(a_no_push_when_full, !(q_push && q_stat.full), "queue overflow")
  `POB_ASSERT_IMP(a_pop_needs_entry, q_pop, !q_stat.empty, "queue underflow")
  `POB_ASSERT_NEXT(a_push_lands, q_push, !q_stat.empty, "pushed entry missing")

endmodule
